/* src/input_retransmit_tracker_macros.svh */
// ---------------------------------------------------------------------------
// input_retransmit_tracker_macros
// Assertion helpers shared by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef INPUT_RETRANSMIT_TRACKER_MACROS_SVH
`define INPUT_RETRANSMIT_TRACKER_MACROS_SVH

// same-cycle implication, held off during reset
`define IRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define IRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/irt_pkg.sv */
// ---------------------------------------------------------------------------
// irt_pkg
// Shared types and constants of the retransmit tracker.
// ---------------------------------------------------------------------------
package irt_pkg;

    localparam int MAX_RECORDS_DEF   = 64;
    localparam int BYTE_CAPACITY_DEF = 4096;

    localparam logic [15:0] FIRST_RETRY_RST = 16'd250;
    localparam logic [15:0] LATER_RETRY_RST = 16'd1000;
    localparam logic [7:0]  COUNT_TOP       = 8'd255;
    localparam logic [7:0]  LATER_SENDS     = 8'd2;

    typedef enum logic [2:0] {
        OP_RESTART     = 3'd0,
        OP_APPEND_KEYS = 3'd1,
        OP_APPEND_DIFF = 3'd2,
        OP_ACK         = 3'd3,
        OP_FIND        = 3'd4,
        OP_MARK_SENT   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NONE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_START_NUMBER = 2'd0,
        REG_FIRST_RETRY  = 2'd1,
        REG_LATER_RETRY  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR
    } t_state;

    // per-record verdict from the shared compare unit
    typedef struct packed {
        logic num_le_ack;
        logic due;
    } t_eval_res;

endpackage

/* src/input_retransmit_tracker.sv */
// ---------------------------------------------------------------------------
// input_retransmit_tracker
// Table of unacknowledged input records with cumulative acknowledge.
// ---------------------------------------------------------------------------
// Records live in a circular buffer in one memory, oldest at the head
// pointer; acknowledge moves the head and a byte base instead of copying.
// Restart, append and invalid operations finish straight from idle; mark
// sent reads the record, then writes it back. Acknowledge and retransmit
// search walk the table through the single memory read port and one
// shared compare unit, one record per cycle. One word is worked at a
// time; the next is taken once the result word has been taken.
module input_retransmit_tracker #(
    parameter int MAX_RECORDS   = irt_pkg::MAX_RECORDS_DEF,
    parameter int BYTE_CAPACITY = irt_pkg::BYTE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [12:0] i_byte_length,
    input  logic [63:0] i_ack_number,
    input  logic [47:0] i_now_ms,
    input  logic [5:0]  i_slot_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_found_index,
    output logic [63:0] o_found_number,
    output logic [12:0] o_found_offset,
    output logic [12:0] o_found_length,
    output logic        o_found_is_diff,
    output logic [12:0] o_freed_bytes,
    output logic [6:0]  o_cut_records
);
    import irt_pkg::*;
    `include "input_retransmit_tracker_macros.svh"

    localparam int PW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int BW = $clog2(BYTE_CAPACITY + 1);
    localparam int RW = 64 + BW + BW + 48 + 8 + 1;
    // record field positions
    localparam int DIFF_B = 0;
    localparam int CNT_L  = 1;
    localparam int TIME_L = 9;
    localparam int LEN_L  = 57;
    localparam int OFF_L  = LEN_L + BW;
    localparam int NUM_L  = OFF_L + BW;

    // physical slot of a position counted from the oldest
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [CW-1:0] pos);
        int sum;
        sum = int'(head) + int'(pos);
        if (sum >= MAX_RECORDS) begin
            sum = sum - MAX_RECORDS;
        end
        return PW'(sum);
    endfunction

    t_state            r_state, n_state;
    logic [63:0]       r_start;
    logic [15:0]       r_first, r_later;
    logic [63:0]       r_last_acked, n_last_acked;
    logic [63:0]       r_newest, n_newest;
    logic [CW-1:0]     r_count, n_count;
    logic [BW-1:0]     r_bytes, n_bytes;
    logic [PW-1:0]     r_head, n_head;
    logic [BW-1:0]     r_base, n_base;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_epos, n_epos;
    logic              r_vld, n_vld;
    logic              r_is_find, n_is_find;
    logic [63:0]       r_ack, n_ack;
    logic [47:0]       r_now, n_now;
    logic [BW:0]       r_lastend, n_lastend;
    logic              r_out_vld, n_out_vld;
    logic [1:0]        r_status, n_status;
    logic [5:0]        r_fidx, n_fidx;
    logic [63:0]       r_fnum, n_fnum;
    logic [12:0]       r_foff, n_foff;
    logic [12:0]       r_flen, n_flen;
    logic              r_fdiff, n_fdiff;
    logic [12:0]       r_cbytes, n_cbytes;
    logic [6:0]        r_crec, n_crec;

    logic              w_we;
    logic [PW-1:0]     w_waddr;
    logic [RW-1:0]     w_wdata;
    logic [RW-1:0]     w_rdata;
    t_eval_res         w_ev;
    logic [BW-1:0]     w_ev_off;

    // record memory
    irt_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (phys(r_head, r_pos)),
        .o_rdata (w_rdata)
    );

    // shared compare unit on the word just read
    irt_eval #(.BW(BW)) u_eval (
        .i_rec_number (w_rdata[NUM_L +: 64]),
        .i_rec_offset (w_rdata[OFF_L +: BW]),
        .i_rec_sent   (w_rdata[TIME_L +: 48]),
        .i_rec_count  (w_rdata[CNT_L +: 8]),
        .i_base       (r_base),
        .i_ack        (r_ack),
        .i_last_acked (r_last_acked),
        .i_now        (r_now),
        .i_first      (r_first),
        .i_later      (r_later),
        .o_res        (w_ev),
        .o_offset     (w_ev_off)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 64'd0;
            r_first <= FIRST_RETRY_RST;
            r_later <= LATER_RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_START_NUMBER: r_start <= i_cfg_data;
                REG_FIRST_RETRY:  r_first <= i_cfg_data[15:0];
                REG_LATER_RETRY:  r_later <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_acked <= 64'd0;
            r_newest     <= 64'd0;
            r_count      <= '0;
            r_bytes      <= '0;
            r_head       <= '0;
            r_base       <= '0;
            r_pos        <= '0;
            r_vld        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_acked <= n_last_acked;
            r_newest     <= n_newest;
            r_count      <= n_count;
            r_bytes      <= n_bytes;
            r_head       <= n_head;
            r_base       <= n_base;
            r_pos        <= n_pos;
            r_vld        <= n_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_epos    <= n_epos;
        r_is_find <= n_is_find;
        r_ack     <= n_ack;
        r_now     <= n_now;
        r_lastend <= n_lastend;
        r_status  <= n_status;
        r_fidx    <= n_fidx;
        r_fnum    <= n_fnum;
        r_foff    <= n_foff;
        r_flen    <= n_flen;
        r_fdiff   <= n_fdiff;
        r_cbytes  <= n_cbytes;
        r_crec    <= n_crec;
    end

    // sequencer
    always_comb begin
        logic [63:0]   v_ackc;
        logic [BW:0]   v_end;
        logic [BW-1:0] v_cb;
        logic [CW-1:0] v_cut;
        logic          v_fin_ack;
        logic          v_stop;
        logic [7:0]    v_cnt;

        n_state      = r_state;
        n_last_acked = r_last_acked;
        n_newest     = r_newest;
        n_count      = r_count;
        n_bytes      = r_bytes;
        n_head       = r_head;
        n_base       = r_base;
        n_pos        = r_pos;
        n_epos       = r_epos;
        n_vld        = r_vld;
        n_is_find    = r_is_find;
        n_ack        = r_ack;
        n_now        = r_now;
        n_lastend    = r_lastend;
        n_out_vld    = r_out_vld;
        n_status     = r_status;
        n_fidx       = r_fidx;
        n_fnum       = r_fnum;
        n_foff       = r_foff;
        n_flen       = r_flen;
        n_fdiff      = r_fdiff;
        n_cbytes     = r_cbytes;
        n_crec       = r_crec;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        v_ackc       = 64'd0;
        v_end        = r_lastend;
        v_cb         = '0;
        v_cut        = '0;
        v_fin_ack    = 1'b0;
        v_stop       = 1'b0;
        v_cnt        = 8'd0;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_status = ST_DONE;
                    n_fidx   = '0;
                    n_fnum   = '0;
                    n_foff   = '0;
                    n_flen   = '0;
                    n_fdiff  = 1'b0;
                    n_cbytes = '0;
                    n_crec   = '0;
                    case (i_operation)
                        OP_RESTART: begin
                            n_out_vld    = 1'b1;
                            n_last_acked = r_start;
                            n_newest     = r_start;
                            n_count      = '0;
                            n_bytes      = '0;
                            n_head       = '0;
                            n_base       = '0;
                        end
                        OP_APPEND_KEYS, OP_APPEND_DIFF: begin
                            n_out_vld = 1'b1;
                            if (i_byte_length == 13'd0) begin
                                n_status = ST_DONE;
                            end else if (int'(r_count) >= MAX_RECORDS ||
                                         int'(i_byte_length) >
                                         BYTE_CAPACITY - int'(r_bytes)) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_newest = r_newest + 64'd1;
                                n_count  = r_count + CW'(1);
                                n_bytes  = r_bytes + BW'(i_byte_length);
                                w_we     = 1'b1;
                                w_waddr  = phys(r_head, r_count);
                                w_wdata  = {r_newest + 64'd1, r_base + r_bytes,
                                            BW'(i_byte_length), i_now_ms, 8'd1,
                                            (i_operation == OP_APPEND_DIFF)};
                                n_fidx   = 6'(r_count);
                                n_fnum   = r_newest + 64'd1;
                                n_foff   = 13'(r_bytes);
                                n_flen   = i_byte_length;
                                n_fdiff  = (i_operation == OP_APPEND_DIFF);
                            end
                        end
                        OP_ACK: begin
                            v_ackc = (i_ack_number > r_newest) ? r_newest : i_ack_number;
                            if (v_ackc <= r_last_acked) begin
                                n_out_vld = 1'b1;
                            end else begin
                                n_last_acked = v_ackc;
                                n_ack        = v_ackc;
                                n_is_find    = 1'b0;
                                n_pos        = '0;
                                n_vld        = 1'b0;
                                n_lastend    = '0;
                                n_state      = S_SCAN;
                            end
                        end
                        OP_FIND: begin
                            n_now     = i_now_ms;
                            n_is_find = 1'b1;
                            n_pos     = '0;
                            n_vld     = 1'b0;
                            n_state   = S_SCAN;
                        end
                        OP_MARK_SENT: begin
                            if (int'(i_slot_index) >= int'(r_count)) begin
                                n_out_vld = 1'b1;
                                n_status  = ST_REFUSED;
                            end else begin
                                n_pos   = CW'(i_slot_index);
                                n_now   = i_now_ms;
                                n_state = S_MARK_RD;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                            n_status  = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // judge the word read last cycle
                if (r_vld) begin
                    if (r_is_find) begin
                        if (w_ev.due) begin
                            v_stop    = 1'b1;
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                            n_fidx    = 6'(r_epos);
                            n_fnum    = w_rdata[NUM_L +: 64];
                            n_foff    = 13'(w_ev_off);
                            n_flen    = 13'(w_rdata[LEN_L +: BW]);
                            n_fdiff   = w_rdata[DIFF_B];
                        end
                    end else if (!w_ev.num_le_ack) begin
                        v_stop    = 1'b1;
                        v_fin_ack = 1'b1;
                        v_cut     = r_epos;
                    end else begin
                        v_end     = {1'b0, w_ev_off} + {1'b0, w_rdata[LEN_L +: BW]};
                        n_lastend = v_end;
                    end
                end
                // issue the next read or close the walk
                if (!v_stop) begin
                    if (r_pos < r_count) begin
                        n_epos = r_pos;
                        n_vld  = 1'b1;
                        n_pos  = r_pos + CW'(1);
                    end else begin
                        n_vld = 1'b0;
                        if (r_is_find) begin
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                            n_status  = ST_NONE;
                        end else begin
                            v_fin_ack = 1'b1;
                            v_cut     = r_count;
                        end
                    end
                end
                // drop the acknowledged prefix
                if (v_fin_ack) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (v_cut != '0) begin
                        v_cb     = (v_end > {1'b0, r_bytes}) ? r_bytes : v_end[BW-1:0];
                        n_bytes  = r_bytes - v_cb;
                        n_base   = r_base + v_cb;
                        n_head   = phys(r_head, v_cut);
                        n_count  = r_count - v_cut;
                        n_cbytes = 13'(v_cb);
                        n_crec   = 7'(v_cut);
                    end
                end
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                v_cnt   = w_rdata[CNT_L +: 8];
                if (v_cnt < COUNT_TOP) begin
                    v_cnt = v_cnt + 8'd1;
                end
                w_we      = 1'b1;
                w_waddr   = phys(r_head, r_pos);
                w_wdata   = {w_rdata[RW-1:LEN_L], r_now, v_cnt, w_rdata[DIFF_B]};
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
                n_fidx    = 6'(r_pos);
                n_fnum    = w_rdata[NUM_L +: 64];
                n_foff    = 13'(w_ev_off);
                n_flen    = 13'(w_rdata[LEN_L +: BW]);
                n_fdiff   = w_rdata[DIFF_B];
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready         = (r_state == S_IDLE) && !r_out_vld;
    assign o_valid         = r_out_vld;
    assign o_status        = r_status;
    assign o_found_index   = r_fidx;
    assign o_found_number  = r_fnum;
    assign o_found_offset  = r_foff;
    assign o_found_length  = r_flen;
    assign o_found_is_diff = r_fdiff;
    assign o_freed_bytes   = r_cbytes;
    assign o_cut_records   = r_crec;

    // checks on table bookkeeping and sequencing
    `IRT_ASSERT_SAME(a_count_bound, 1'b1, int'(r_count) <= MAX_RECORDS, "record count overflow")
    `IRT_ASSERT_SAME(a_bytes_bound, 1'b1, int'(r_bytes) <= BYTE_CAPACITY, "byte space overflow")
    `IRT_ASSERT_SAME(a_busy_no_out, r_state != S_IDLE, !r_out_vld, "result while busy")
    `IRT_ASSERT_NEXT(a_mark_follow, r_state == S_MARK_RD, r_state == S_MARK_WR, "mark sequence broken")
endmodule

/* src/irt_ram.sv */
// ---------------------------------------------------------------------------
// irt_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/irt_eval.sv */
// ---------------------------------------------------------------------------
// irt_eval
// Shared compare unit: judges one stored record against the acknowledge
// bound and its retry time, and rebases its byte offset.
// ---------------------------------------------------------------------------
module irt_eval #(
    parameter int BW = 13
) (
    input  logic [63:0]         i_rec_number,
    input  logic [BW-1:0]       i_rec_offset,
    input  logic [47:0]         i_rec_sent,
    input  logic [7:0]          i_rec_count,
    input  logic [BW-1:0]       i_base,
    input  logic [63:0]         i_ack,
    input  logic [63:0]         i_last_acked,
    input  logic [47:0]         i_now,
    input  logic [15:0]         i_first,
    input  logic [15:0]         i_later,
    output irt_pkg::t_eval_res  o_res,
    output logic [BW-1:0]       o_offset
);
    import irt_pkg::*;

    logic [47:0] w_age;
    logic [15:0] w_retry;

    // age clamps at zero when the clock reads earlier than the send
    assign w_age   = (i_now >= i_rec_sent) ? (i_now - i_rec_sent) : 48'd0;
    assign w_retry = (i_rec_count < LATER_SENDS) ? i_first : i_later;

    assign o_res.num_le_ack = (i_rec_number <= i_ack);
    assign o_res.due = (i_rec_number > i_last_acked) &&
                       ((i_rec_count == 8'd0) || (w_age >= {32'd0, w_retry}));

    // offsets are stored absolute, modulo the byte space width
    assign o_offset = i_rec_offset - i_base;
endmodule
